### hw/rtl/ccrf_pkg.sv
// ----------------------------------------------------------------------------
// ccrf_pkg: shared definitions for the clear color rectangle fill engine
// Pixel format and register codes, queue status, 565 channel scaling.
// ----------------------------------------------------------------------------
package ccrf_pkg;

    localparam int COORD_BITS_DEF = 14;
    localparam int LAYER_BITS_DEF = 11;
    localparam int ADDR_BITS_DEF  = 48;

    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int COLOR_W     = 32;
    localparam int STRIDE_W    = 32;
    localparam int BYTES_W     = 3;

    localparam logic [BYTES_W-1:0] BYTES_16BPP = 3'd2;
    localparam logic [BYTES_W-1:0] BYTES_32BPP = 3'd4;

    typedef enum logic [2:0] {
        FMT_RGBA8   = 3'd0,
        FMT_RGBX8   = 3'd1,
        FMT_BGRA8   = 3'd2,
        FMT_BGRX8   = 3'd3,
        FMT_R5G6B5  = 3'd4,
        FMT_B5G6R5  = 3'd5,
        FMT_RGB10A2 = 3'd6,
        FMT_BGR10A2 = 3'd7
    } pix_fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXEL_FORMAT = 3'd0,
        REG_CLEAR_RED    = 3'd1,
        REG_CLEAR_GREEN  = 3'd2,
        REG_CLEAR_BLUE   = 3'd3,
        REG_CLEAR_ALPHA  = 3'd4,
        REG_SURFACE_BASE = 3'd5,
        REG_ROW_STRIDE   = 3'd6,
        REG_SLICE_STRIDE = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // rounded c * maxv / 255, division by 255 done as add and shift (exact below 2^16)
    function automatic logic [5:0] scale_from8(input logic [7:0] c, input logic [5:0] maxv);
        logic [13:0] num;
        logic [14:0] acc;
        num = 14'(c) * 14'(maxv) + 14'd127;
        acc = 15'(num) + 15'(num >> 8) + 15'd1;
        return acc[13:8];
    endfunction

endpackage

### hw/rtl/clear_color_rect_fill.sv
// A tick reaches m_axis through the queue and the output register; a start gives no result.
// Throughput: one pixel write per cycle while ticks stream and m_axis is ready.
// A start holds the fill side through its queue pop and the five-stage setup pipeline.
// Reset: aresetn is synchronous, active low; it empties the queue, drops any fill in
// progress and restores the register defaults (strides one, all others zero).
// ----------------------------------------------------------------------------
// clear_color_rect_fill: rectangle clear-fill engine
// Start requests load a rectangle and layer range, ticks emit one pixel write each while a fill runs.
// ----------------------------------------------------------------------------
module clear_color_rect_fill #(
    parameter int COORD_BITS = ccrf_pkg::COORD_BITS_DEF,
    parameter int LAYER_BITS = ccrf_pkg::LAYER_BITS_DEF,
    parameter int ADDR_BITS  = ccrf_pkg::ADDR_BITS_DEF,
    localparam int S_FIELDS_W = 4 * COORD_BITS + 2 + 2 * LAYER_BITS,
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8,
    localparam int M_FIELDS_W = ADDR_BITS + ccrf_pkg::COLOR_W + ccrf_pkg::BYTES_W,
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ccrf_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [ADDR_BITS-1:0]           cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // rect_x, rect_y, rect_width, rect_height, layer_lo, layer_hi
    input  logic [S_TDATA_W-1:0]           s_axis_tdata,
    // req_type
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // write_address, write_data, write_bytes
    output logic [M_TDATA_W-1:0]           m_axis_tdata,
    output logic                           m_axis_tlast
);
    localparam int ENTRY_W = S_FIELDS_W + 2;

    ccrf_pkg::pix_fmt_t            pixel_format_reg;
    logic [ccrf_pkg::COLOR_W-1:0]  clear_red_reg, clear_green_reg, clear_blue_reg, clear_alpha_reg;
    logic [ADDR_BITS-1:0]          surface_base_reg;
    logic [ccrf_pkg::STRIDE_W-1:0] row_stride_reg, slice_stride_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg <= ccrf_pkg::FMT_RGBA8;
            clear_red_reg    <= '0;
            clear_green_reg  <= '0;
            clear_blue_reg   <= '0;
            clear_alpha_reg  <= '0;
            surface_base_reg <= '0;
            row_stride_reg   <= ccrf_pkg::STRIDE_W'(1);
            slice_stride_reg <= ccrf_pkg::STRIDE_W'(1);
        end else if (cfg_wr_en) begin
            unique case (ccrf_pkg::cfg_reg_t'(cfg_addr))
                ccrf_pkg::REG_PIXEL_FORMAT:
                    pixel_format_reg <= ccrf_pkg::pix_fmt_t'(cfg_wr_data[2:0]);
                ccrf_pkg::REG_CLEAR_RED:    clear_red_reg    <= cfg_wr_data[31:0];
                ccrf_pkg::REG_CLEAR_GREEN:  clear_green_reg  <= cfg_wr_data[31:0];
                ccrf_pkg::REG_CLEAR_BLUE:   clear_blue_reg   <= cfg_wr_data[31:0];
                ccrf_pkg::REG_CLEAR_ALPHA:  clear_alpha_reg  <= cfg_wr_data[31:0];
                ccrf_pkg::REG_SURFACE_BASE: surface_base_reg <= cfg_wr_data;
                ccrf_pkg::REG_ROW_STRIDE:   row_stride_reg   <= cfg_wr_data[31:0];
                ccrf_pkg::REG_SLICE_STRIDE: slice_stride_reg <= cfg_wr_data[31:0];
                default: ;
            endcase
        end
    end

    ccrf_pkg::queue_stat_t q_stat;
    logic                  q_wr_en, q_rd_en;
    logic [ENTRY_W-1:0]    q_wr_data, q_rd_data;

    ccrf_front #(
        .COORD_BITS(COORD_BITS), .LAYER_BITS(LAYER_BITS),
        .S_TDATA_W(S_TDATA_W), .ENTRY_W(ENTRY_W)
    ) u_front (
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .q_stat(q_stat), .q_wr_en(q_wr_en), .q_wr_data(q_wr_data)
    );

    ccrf_fifo #(.WIDTH(ENTRY_W), .DEPTH(ccrf_pkg::QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(q_wr_en), .wr_data(q_wr_data),
        .rd_en(q_rd_en), .rd_data(q_rd_data), .stat(q_stat)
    );

    logic                         setup_go, setup_done;
    logic [COORD_BITS-1:0]        setup_x, setup_y;
    logic [LAYER_BITS-1:0]        setup_layer;
    logic [ccrf_pkg::COLOR_W-1:0] setup_color;
    logic [ccrf_pkg::BYTES_W-1:0] setup_bytes;
    logic [ADDR_BITS-1:0]         setup_address;

    ccrf_setup #(
        .COORD_BITS(COORD_BITS), .LAYER_BITS(LAYER_BITS), .ADDR_BITS(ADDR_BITS)
    ) u_setup (
        .aclk(aclk), .aresetn(aresetn), .go(setup_go),
        .rect_x(setup_x), .rect_y(setup_y), .layer_lo(setup_layer),
        .pixel_format(pixel_format_reg),
        .clear_red(clear_red_reg), .clear_green(clear_green_reg),
        .clear_blue(clear_blue_reg), .clear_alpha(clear_alpha_reg),
        .surface_base(surface_base_reg),
        .row_stride(row_stride_reg), .slice_stride(slice_stride_reg),
        .done(setup_done), .packed_color(setup_color),
        .pixel_bytes(setup_bytes), .start_address(setup_address)
    );

    logic [ADDR_BITS-1:0]         out_address;
    logic [ccrf_pkg::COLOR_W-1:0] out_data;
    logic [ccrf_pkg::BYTES_W-1:0] out_bytes;

    ccrf_back #(
        .COORD_BITS(COORD_BITS), .LAYER_BITS(LAYER_BITS),
        .ADDR_BITS(ADDR_BITS), .ENTRY_W(ENTRY_W)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_rd_data(q_rd_data), .q_stat(q_stat), .q_rd_en(q_rd_en),
        .setup_go(setup_go), .setup_x(setup_x), .setup_y(setup_y),
        .setup_layer(setup_layer), .setup_done(setup_done),
        .setup_color(setup_color), .setup_bytes(setup_bytes),
        .setup_address(setup_address),
        .row_stride(row_stride_reg), .slice_stride(slice_stride_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_address(out_address), .out_data(out_data),
        .out_bytes(out_bytes), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = M_TDATA_W'({out_bytes, out_data, out_address});

endmodule

### hw/rtl/ccrf_fifo.sv
// ----------------------------------------------------------------------------
// ccrf_fifo: short command queue
// Register queue that decouples the accept side from the fill side.
// ----------------------------------------------------------------------------
module ccrf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ccrf_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output ccrf_pkg::queue_stat_t stat
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/ccrf_front.sv
// ----------------------------------------------------------------------------
// ccrf_front: request intake
// Accepts stream transfers, classifies start against tick, flags empty starts.
// ----------------------------------------------------------------------------
module ccrf_front #(
    parameter int COORD_BITS = ccrf_pkg::COORD_BITS_DEF,
    parameter int LAYER_BITS = ccrf_pkg::LAYER_BITS_DEF,
    parameter int S_TDATA_W  = 80,
    parameter int ENTRY_W    = 82
) (
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  ccrf_pkg::queue_stat_t q_stat,
    output logic                  q_wr_en,
    output logic [ENTRY_W-1:0]    q_wr_data
);
    localparam int DIM_W    = COORD_BITS + 1;
    localparam int W_OFS    = 2 * COORD_BITS;
    localparam int H_OFS    = W_OFS + DIM_W;
    localparam int F_OFS    = H_OFS + DIM_W;
    localparam int L_OFS    = F_OFS + LAYER_BITS;
    localparam int FIELDS_W = L_OFS + LAYER_BITS;

    logic [DIM_W-1:0]      rect_width, rect_height;
    logic [LAYER_BITS-1:0] layer_lo, layer_hi;
    logic                  is_start, run;

    assign rect_width  = s_axis_tdata[W_OFS +: DIM_W];
    assign rect_height = s_axis_tdata[H_OFS +: DIM_W];
    assign layer_lo    = s_axis_tdata[F_OFS +: LAYER_BITS];
    assign layer_hi    = s_axis_tdata[L_OFS +: LAYER_BITS];

    // req_type low means start
    assign is_start = !s_axis_tuser;
    assign run      = (rect_width != '0) && (rect_height != '0) && (layer_lo <= layer_hi);

    assign s_axis_tready = !q_stat.full;
    assign q_wr_en       = s_axis_tvalid && !q_stat.full;
    assign q_wr_data     = {is_start, run, s_axis_tdata[FIELDS_W-1:0]};

endmodule

### hw/rtl/ccrf_unorm.sv
// ----------------------------------------------------------------------------
// ccrf_unorm: fp32 to unorm conversion pipeline
// Four register stages: scaled product, fp32 rounding, add one half, round and truncate.
// ----------------------------------------------------------------------------
module ccrf_unorm #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic [31:0]  value_bits,
    output logic [W-1:0] unorm
);
    localparam int MANT_W   = 24;
    localparam int FRAC_W   = 26;
    localparam int PW       = MANT_W + W;
    localparam int XW       = PW + 3;
    localparam int LDW      = $clog2(PW);
    localparam int LDW2     = $clog2(XW);
    localparam int EXP_BIAS = 127;
    localparam int EXP_OFS  = 150;

    // stage 1: classify and form mantissa times (2^W - 1)
    logic              sign_b, is_nan, pos, ge1;
    logic [7:0]        expo;
    logic [22:0]       frac;
    logic [MANT_W-1:0] mant;
    logic [PW-1:0]     prod_next;
    logic [7:0]        scale_next;

    logic              zero_s1_reg, max_s1_reg;
    logic [PW-1:0]     prod_s1_reg;
    logic [7:0]        scale_s1_reg;

    assign sign_b     = value_bits[31];
    assign expo       = value_bits[30:23];
    assign frac       = value_bits[22:0];
    assign is_nan     = (expo == 8'hFF) && (frac != '0);
    assign pos        = !sign_b && ((expo != '0) || (frac != '0)) && !is_nan;
    assign ge1        = pos && (expo >= 8'(EXP_BIAS));
    assign mant       = {(expo != '0), frac};
    assign prod_next  = (PW'(mant) << W) - PW'(mant);
    assign scale_next = 8'(EXP_OFS) - ((expo == '0) ? 8'd1 : expo);

    always_ff @(posedge aclk) begin
        zero_s1_reg  <= !pos;
        max_s1_reg   <= ge1;
        prod_s1_reg  <= prod_next;
        scale_s1_reg <= scale_next;
    end

    // stage 2: round the product to 24 significant bits, ties to even
    logic [LDW-1:0] lead1, d1;
    logic [PW-1:0]  keep1, rem1, half1;
    logic           inc1;
    logic [PW:0]    rnd_next;

    logic           zero_s2_reg, max_s2_reg;
    logic [PW:0]    rnd_s2_reg;
    logic [7:0]     scale_s2_reg;

    always_comb begin
        lead1 = '0;
        for (int i = 0; i < PW; i++) begin
            if (prod_s1_reg[i]) begin
                lead1 = LDW'(i);
            end
        end
        d1       = (lead1 > LDW'(MANT_W - 1)) ? lead1 - LDW'(MANT_W - 1) : '0;
        keep1    = prod_s1_reg >> d1;
        rem1     = prod_s1_reg & ((PW'(1) << d1) - PW'(1));
        half1    = (d1 == '0) ? '0 : (PW'(1) << (d1 - 1'b1));
        inc1     = (d1 != '0) && ((rem1 > half1) || ((rem1 == half1) && keep1[0]));
        rnd_next = ((PW + 1)'(keep1) + (PW + 1)'(inc1)) << d1;
    end

    always_ff @(posedge aclk) begin
        zero_s2_reg  <= zero_s1_reg;
        max_s2_reg   <= max_s1_reg;
        rnd_s2_reg   <= rnd_next;
        scale_s2_reg <= scale_s1_reg;
    end

    // stage 3: align to fixed point with 26 fraction bits and add one half
    logic [XW-1:0] xv, pf, sum_next;
    logic [7:0]    sh;
    logic          sticky_next;

    logic          zero_s3_reg, max_s3_reg, sticky_s3_reg;
    logic [XW-1:0] sum_s3_reg;

    always_comb begin
        xv = {rnd_s2_reg, 2'b00};
        sh = scale_s2_reg - 8'(MANT_W);
        if (sh >= 8'(XW)) begin
            pf          = '0;
            sticky_next = (xv != '0);
        end else begin
            pf          = xv >> sh;
            sticky_next = ((xv & ((XW'(1) << sh) - XW'(1))) != '0);
        end
        sum_next = pf + (XW'(1) << (FRAC_W - 1));
    end

    always_ff @(posedge aclk) begin
        zero_s3_reg   <= zero_s2_reg;
        max_s3_reg    <= max_s2_reg;
        sticky_s3_reg <= sticky_next;
        sum_s3_reg    <= sum_next;
    end

    // stage 4: round the sum to 24 significant bits, then truncate
    logic [LDW2-1:0] lead2, d2;
    logic [XW-1:0]   keep2, rem2, half2;
    logic            inc2;
    logic [XW:0]     rnd2, int2;
    logic [W-1:0]    unorm_next;

    always_comb begin
        lead2 = '0;
        for (int i = 0; i < XW; i++) begin
            if (sum_s3_reg[i]) begin
                lead2 = LDW2'(i);
            end
        end
        // sum is at least one half, so at least two bits drop out
        d2    = lead2 - LDW2'(MANT_W - 1);
        keep2 = sum_s3_reg >> d2;
        rem2  = sum_s3_reg & ((XW'(1) << d2) - XW'(1));
        half2 = XW'(1) << (d2 - 1'b1);
        inc2  = (rem2 > half2) || ((rem2 == half2) && (sticky_s3_reg || keep2[0]));
        rnd2  = ((XW + 1)'(keep2) + (XW + 1)'(inc2)) << d2;
        int2  = rnd2 >> FRAC_W;
        if (zero_s3_reg) begin
            unorm_next = '0;
        end else if (max_s3_reg) begin
            unorm_next = '1;
        end else begin
            unorm_next = int2[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        unorm <= unorm_next;
    end

endmodule

### hw/rtl/ccrf_setup.sv
// ----------------------------------------------------------------------------
// ccrf_setup: start setup pipeline
// Converts the clear color, packs the pixel and computes the start address.
// ----------------------------------------------------------------------------
module ccrf_setup #(
    parameter int COORD_BITS = ccrf_pkg::COORD_BITS_DEF,
    parameter int LAYER_BITS = ccrf_pkg::LAYER_BITS_DEF,
    parameter int ADDR_BITS  = ccrf_pkg::ADDR_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              go,
    input  logic [COORD_BITS-1:0]             rect_x,
    input  logic [COORD_BITS-1:0]             rect_y,
    input  logic [LAYER_BITS-1:0]             layer_lo,
    input  ccrf_pkg::pix_fmt_t                pixel_format,
    input  logic [ccrf_pkg::COLOR_W-1:0]      clear_red,
    input  logic [ccrf_pkg::COLOR_W-1:0]      clear_green,
    input  logic [ccrf_pkg::COLOR_W-1:0]      clear_blue,
    input  logic [ccrf_pkg::COLOR_W-1:0]      clear_alpha,
    input  logic [ADDR_BITS-1:0]              surface_base,
    input  logic [ccrf_pkg::STRIDE_W-1:0]     row_stride,
    input  logic [ccrf_pkg::STRIDE_W-1:0]     slice_stride,
    output logic                              done,
    output logic [ccrf_pkg::COLOR_W-1:0]      packed_color,
    output logic [ccrf_pkg::BYTES_W-1:0]      pixel_bytes,
    output logic [ADDR_BITS-1:0]              start_address
);
    localparam int LAT    = 5;
    localparam int LM_W   = LAYER_BITS + ccrf_pkg::STRIDE_W;
    localparam int YM_W   = COORD_BITS + ccrf_pkg::STRIDE_W;
    localparam int WIDE_W = ADDR_BITS + LM_W + YM_W;

    logic [LAT-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[LAT-2:0], go};
        end
    end
    assign done = valid_reg[LAT-1];

    // address: products, then two partial sums, then the final sum
    logic                 is16;
    logic [LM_W-1:0]      lm_prod;
    logic [YM_W-1:0]      ym_prod;
    logic [ADDR_BITS-1:0] lm_reg, ym_reg, xb_reg, part_a_reg, part_b_reg;
    logic [ADDR_BITS-1:0] addr_s3_reg, addr_s4_reg;
    ccrf_pkg::pix_fmt_t   fmt_s1_reg, fmt_s2_reg, fmt_s3_reg, fmt_s4_reg;
    logic [ccrf_pkg::BYTES_W-1:0] bytes_s1_reg, bytes_s2_reg, bytes_s3_reg, bytes_s4_reg;

    assign is16    = (pixel_format == ccrf_pkg::FMT_R5G6B5) ||
                     (pixel_format == ccrf_pkg::FMT_B5G6R5);
    assign lm_prod = layer_lo * slice_stride;
    assign ym_prod = rect_y * row_stride;

    always_ff @(posedge aclk) begin
        lm_reg       <= ADDR_BITS'(WIDE_W'(lm_prod));
        ym_reg       <= ADDR_BITS'(WIDE_W'(ym_prod));
        xb_reg       <= is16 ? ADDR_BITS'(WIDE_W'(rect_x) << 1) : ADDR_BITS'(WIDE_W'(rect_x) << 2);
        fmt_s1_reg   <= pixel_format;
        bytes_s1_reg <= is16 ? ccrf_pkg::BYTES_16BPP : ccrf_pkg::BYTES_32BPP;
        part_a_reg   <= surface_base + lm_reg;
        part_b_reg   <= ym_reg + xb_reg;
        fmt_s2_reg   <= fmt_s1_reg;
        bytes_s2_reg <= bytes_s1_reg;
        addr_s3_reg  <= part_a_reg + part_b_reg;
        fmt_s3_reg   <= fmt_s2_reg;
        bytes_s3_reg <= bytes_s2_reg;
        addr_s4_reg  <= addr_s3_reg;
        fmt_s4_reg   <= fmt_s3_reg;
        bytes_s4_reg <= bytes_s3_reg;
        start_address <= addr_s4_reg;
        pixel_bytes   <= bytes_s4_reg;
    end

    // channel conversion from the register values through the unorm pipelines
    logic [7:0] r8, g8, b8, a8;
    logic [9:0] r10, g10, b10;
    logic [1:0] a2;

    ccrf_unorm #(.W(8))  u_r8  (.aclk(aclk), .value_bits(clear_red),   .unorm(r8));
    ccrf_unorm #(.W(8))  u_g8  (.aclk(aclk), .value_bits(clear_green), .unorm(g8));
    ccrf_unorm #(.W(8))  u_b8  (.aclk(aclk), .value_bits(clear_blue),  .unorm(b8));
    ccrf_unorm #(.W(8))  u_a8  (.aclk(aclk), .value_bits(clear_alpha), .unorm(a8));
    ccrf_unorm #(.W(10)) u_r10 (.aclk(aclk), .value_bits(clear_red),   .unorm(r10));
    ccrf_unorm #(.W(10)) u_g10 (.aclk(aclk), .value_bits(clear_green), .unorm(g10));
    ccrf_unorm #(.W(10)) u_b10 (.aclk(aclk), .value_bits(clear_blue),  .unorm(b10));
    ccrf_unorm #(.W(2))  u_a2  (.aclk(aclk), .value_bits(clear_alpha), .unorm(a2));

    logic [4:0]  r5, b5;
    logic [5:0]  g6;
    logic [31:0] pack_next;

    always_comb begin
        r5 = 5'(ccrf_pkg::scale_from8(r8, 6'd31));
        g6 = ccrf_pkg::scale_from8(g8, 6'd63);
        b5 = 5'(ccrf_pkg::scale_from8(b8, 6'd31));
        unique case (fmt_s4_reg)
            ccrf_pkg::FMT_RGBA8:   pack_next = {a8, b8, g8, r8};
            ccrf_pkg::FMT_RGBX8:   pack_next = {8'hFF, b8, g8, r8};
            ccrf_pkg::FMT_BGRA8:   pack_next = {a8, r8, g8, b8};
            ccrf_pkg::FMT_BGRX8:   pack_next = {8'hFF, r8, g8, b8};
            ccrf_pkg::FMT_R5G6B5:  pack_next = {16'h0000, b5, g6, r5};
            ccrf_pkg::FMT_B5G6R5:  pack_next = {16'h0000, r5, g6, b5};
            ccrf_pkg::FMT_RGB10A2: pack_next = {a2, b10, g10, r10};
            ccrf_pkg::FMT_BGR10A2: pack_next = {a2, r10, g10, b10};
            default:               pack_next = {a8, b8, g8, r8};
        endcase
    end

    always_ff @(posedge aclk) begin
        packed_color <= pack_next;
    end

endmodule

### hw/rtl/ccrf_back.sv
// ----------------------------------------------------------------------------
// ccrf_back: fill walker
// Pops queued requests, runs the x, y, layer walk, drives the output register.
// ----------------------------------------------------------------------------
module ccrf_back #(
    parameter int COORD_BITS = ccrf_pkg::COORD_BITS_DEF,
    parameter int LAYER_BITS = ccrf_pkg::LAYER_BITS_DEF,
    parameter int ADDR_BITS  = ccrf_pkg::ADDR_BITS_DEF,
    parameter int ENTRY_W    = 82
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ENTRY_W-1:0]            q_rd_data,
    input  ccrf_pkg::queue_stat_t         q_stat,
    output logic                          q_rd_en,
    output logic                          setup_go,
    output logic [COORD_BITS-1:0]         setup_x,
    output logic [COORD_BITS-1:0]         setup_y,
    output logic [LAYER_BITS-1:0]         setup_layer,
    input  logic                          setup_done,
    input  logic [ccrf_pkg::COLOR_W-1:0]  setup_color,
    input  logic [ccrf_pkg::BYTES_W-1:0]  setup_bytes,
    input  logic [ADDR_BITS-1:0]          setup_address,
    input  logic [ccrf_pkg::STRIDE_W-1:0] row_stride,
    input  logic [ccrf_pkg::STRIDE_W-1:0] slice_stride,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ADDR_BITS-1:0]          out_address,
    output logic [ccrf_pkg::COLOR_W-1:0]  out_data,
    output logic [ccrf_pkg::BYTES_W-1:0]  out_bytes,
    output logic                          out_last
);
    localparam int DIM_W = COORD_BITS + 1;
    localparam int Y_OFS = COORD_BITS;
    localparam int W_OFS = 2 * COORD_BITS;
    localparam int H_OFS = W_OFS + DIM_W;
    localparam int F_OFS = H_OFS + DIM_W;
    localparam int L_OFS = F_OFS + LAYER_BITS;
    localparam int R_OFS = L_OFS + LAYER_BITS;
    localparam int S_OFS = R_OFS + 1;

    logic head_start, head_run, slot_free, pop, pop_start, emit;
    logic last_col, last_row, last_all;
    logic [DIM_W:0] col_inc, row_inc;

    logic                         pending_reg, busy_reg, run_reg, out_valid_reg;
    logic [DIM_W-1:0]             col_reg, row_reg, wid_reg, hgt_reg;
    logic [LAYER_BITS-1:0]        lnow_reg, lend_reg;
    logic [ADDR_BITS-1:0]         row_addr_reg, layer_addr_reg, xoff_reg;
    logic [ccrf_pkg::COLOR_W-1:0] color_reg;
    logic [ccrf_pkg::BYTES_W-1:0] bytes_reg;

    assign head_start = q_rd_data[S_OFS];
    assign head_run   = q_rd_data[R_OFS];
    assign slot_free  = !out_valid_reg || out_ready;
    // a start waits for nothing downstream; a tick needs room in the output register
    assign pop        = !q_stat.empty && !pending_reg && (head_start || slot_free);
    assign pop_start  = pop && head_start;
    assign emit       = pop && !head_start && busy_reg;

    assign q_rd_en     = pop;
    assign setup_go    = pop_start;
    assign setup_x     = q_rd_data[0 +: COORD_BITS];
    assign setup_y     = q_rd_data[Y_OFS +: COORD_BITS];
    assign setup_layer = q_rd_data[F_OFS +: LAYER_BITS];

    assign col_inc  = (DIM_W + 1)'(col_reg) + 1'b1;
    assign row_inc  = (DIM_W + 1)'(row_reg) + 1'b1;
    assign last_col = col_inc >= (DIM_W + 1)'(wid_reg);
    assign last_row = row_inc >= (DIM_W + 1)'(hgt_reg);
    assign last_all = last_col && last_row && (lnow_reg >= lend_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= 1'b0;
            busy_reg      <= 1'b0;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop_start) begin
                pending_reg <= 1'b1;
                busy_reg    <= 1'b0;
                run_reg     <= head_run;
            end else if (setup_done) begin
                pending_reg <= 1'b0;
                busy_reg    <= run_reg;
            end else if (emit && last_all) begin
                busy_reg <= 1'b0;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_start) begin
            wid_reg  <= q_rd_data[W_OFS +: DIM_W];
            hgt_reg  <= q_rd_data[H_OFS +: DIM_W];
            lnow_reg <= q_rd_data[F_OFS +: LAYER_BITS];
            lend_reg <= q_rd_data[L_OFS +: LAYER_BITS];
        end
        if (setup_done) begin
            color_reg      <= setup_color;
            bytes_reg      <= setup_bytes;
            row_addr_reg   <= setup_address;
            layer_addr_reg <= setup_address;
            xoff_reg       <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
        end else if (emit && !last_all) begin
            if (!last_col) begin
                col_reg  <= col_inc[DIM_W-1:0];
                xoff_reg <= xoff_reg + ADDR_BITS'(bytes_reg);
            end else begin
                col_reg  <= '0;
                xoff_reg <= '0;
                if (!last_row) begin
                    row_reg      <= row_inc[DIM_W-1:0];
                    row_addr_reg <= row_addr_reg + ADDR_BITS'(row_stride);
                end else begin
                    row_reg        <= '0;
                    lnow_reg       <= lnow_reg + 1'b1;
                    layer_addr_reg <= layer_addr_reg + ADDR_BITS'(slice_stride);
                    row_addr_reg   <= layer_addr_reg + ADDR_BITS'(slice_stride);
                end
            end
        end
        if (emit) begin
            out_address <= row_addr_reg + xoff_reg;
            out_data    <= color_reg;
            out_bytes   <= bytes_reg;
            out_last    <= last_all;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### hw/rtl/ccrf_checker.sv
// ----------------------------------------------------------------------------
// ccrf_checker: port-level checks for the clear-fill engine
// Watches the result stream of the top level; attached with bind.
// ----------------------------------------------------------------------------
module ccrf_checker #(
    parameter int ADDR_BITS = ccrf_pkg::ADDR_BITS_DEF,
    localparam int M_FIELDS_W = ADDR_BITS + ccrf_pkg::COLOR_W + ccrf_pkg::BYTES_W,
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast
);
    localparam int DATA_OFS  = ADDR_BITS;
    localparam int BYTES_OFS = ADDR_BITS + ccrf_pkg::COLOR_W;

    logic [ccrf_pkg::BYTES_W-1:0] write_bytes;
    logic [15:0]                  data_upper;

    assign write_bytes = m_axis_tdata[BYTES_OFS +: ccrf_pkg::BYTES_W];
    assign data_upper  = m_axis_tdata[DATA_OFS + 16 +: 16];

    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_bytes_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (write_bytes == ccrf_pkg::BYTES_16BPP ||
                           write_bytes == ccrf_pkg::BYTES_32BPP))
        else $error("illegal write size");

    a_16bpp_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && write_bytes == ccrf_pkg::BYTES_16BPP |-> data_upper == '0)
        else $error("16 bpp write with upper data bits set");

endmodule

bind clear_color_rect_fill ccrf_checker #(.ADDR_BITS(ADDR_BITS)) u_ccrf_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);

### tb/tb_clear_color_rect_fill.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the clear color rectangle fill engine
// Start and tick requests go in on s_axis; every pixel write on m_axis is
// compared with a local fill predictor (fp32 to unorm packing, address walk).
// ----------------------------------------------------------------------------
module tb;

    localparam int S_W = 80;
    localparam int M_W = 88;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        bit        tick;
        bit [13:0] x;
        bit [13:0] y;
        bit [14:0] w;
        bit [14:0] h;
        bit [10:0] fl;
        bit [10:0] ll;
    } fill_req_t;

    typedef struct {
        logic [47:0] addr;
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
    } pixel_wr_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [ccrf_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [47:0] cfg_wr_data = '0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [S_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [M_W-1:0] m_axis_tdata;
    logic m_axis_tlast;

    clear_color_rect_fill i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    initial forever #5 aclk = ~aclk;

    // register copies
    ccrf_pkg::pix_fmt_t fmt_reg = ccrf_pkg::FMT_RGBA8;
    logic [31:0] clear_reg [4] = '{default: '0};
    logic [47:0] base_reg = '0;
    logic [31:0] row_stride_reg = 32'd1;
    logic [31:0] slice_stride_reg = 32'd1;

    // fill walker copy
    bit          fill_busy = 0;
    logic [31:0] fill_colour = '0;
    logic [2:0]  fill_bytes = ccrf_pkg::BYTES_32BPP;
    int unsigned col_n, row_n, wid_n, hgt_n;
    logic [10:0] layer_cur, layer_last;
    logic [47:0] row_addr, layer_addr, x_off;

    pixel_wr_t pending_writes[$];
    int errors = 0;
    int items_sent = 0;
    int starts_sent = 0;
    int writes_checked = 0;
    bit idle_on = 1;
    bit long_hold = 0;

    // exact fp32 rounding (nearest even) of a value held in units of 2^-200
    function automatic logic [255:0] fp32_round(input logic [255:0] v);
        int h;
        int lsb;
        logic [255:0] keep, rem, half;
        h = -1;
        for (int i = 0; i < 256; i++) if (v[i]) h = i;
        if (h <= 23) return v;
        lsb = h - 23;
        keep = v >> lsb;
        rem = v & ((256'd1 << lsb) - 1);
        half = 256'd1 << (lsb - 1);
        if (rem > half || (rem == half && keep[0])) keep = keep + 1;
        return keep << lsb;
    endfunction

    function automatic logic [9:0] chan_unorm(input logic [31:0] f, input int unsigned mx);
        logic [255:0] acc;
        logic [23:0] man;
        int ex;
        if (f[31] || f[30:0] == 0) return 0;
        if (f[30:23] == 8'hFF) return (f[22:0] == 0) ? 10'(mx) : 10'd0;
        if (f[30:0] >= 31'h3F800000) return 10'(mx);
        man = (f[30:23] == 0) ? {1'b0, f[22:0]} : {1'b1, f[22:0]};
        ex = (f[30:23] == 0) ? 1 : int'(f[30:23]);
        acc = 256'(man) * 256'(mx);
        acc = fp32_round(acc << (ex + 50));
        acc = fp32_round(acc + (256'd1 << 199));
        return 10'(acc >> 200);
    endfunction

    function automatic logic [31:0] clear_pixel(input ccrf_pkg::pix_fmt_t f);
        logic [31:0] r, g, b, a, r10, g10, b10, a2, r5, g6, b5;
        r = chan_unorm(clear_reg[0], 255);
        g = chan_unorm(clear_reg[1], 255);
        b = chan_unorm(clear_reg[2], 255);
        a = chan_unorm(clear_reg[3], 255);
        r10 = chan_unorm(clear_reg[0], 1023);
        g10 = chan_unorm(clear_reg[1], 1023);
        b10 = chan_unorm(clear_reg[2], 1023);
        a2 = chan_unorm(clear_reg[3], 3);
        r5 = (r * 31 + 127) / 255;
        g6 = (g * 63 + 127) / 255;
        b5 = (b * 31 + 127) / 255;
        case (f)
            ccrf_pkg::FMT_RGBX8:   return r | (g << 8) | (b << 16) | (32'd255 << 24);
            ccrf_pkg::FMT_BGRA8:   return b | (g << 8) | (r << 16) | (a << 24);
            ccrf_pkg::FMT_BGRX8:   return b | (g << 8) | (r << 16) | (32'd255 << 24);
            ccrf_pkg::FMT_R5G6B5:  return r5 | (g6 << 5) | (b5 << 11);
            ccrf_pkg::FMT_B5G6R5:  return b5 | (g6 << 5) | (r5 << 11);
            ccrf_pkg::FMT_RGB10A2: return r10 | (g10 << 10) | (b10 << 20) | (a2 << 30);
            ccrf_pkg::FMT_BGR10A2: return b10 | (g10 << 10) | (r10 << 20) | (a2 << 30);
            default:               return r | (g << 8) | (b << 16) | (a << 24);
        endcase
    endfunction

    task automatic predict_fill(input fill_req_t q);
        pixel_wr_t wr;
        bit lc, lr, lst;
        logic [63:0] sum;
        if (!q.tick) begin
            wid_n = q.w;
            hgt_n = q.h;
            layer_cur = q.fl;
            layer_last = q.ll;
            fill_bytes = (fmt_reg == ccrf_pkg::FMT_R5G6B5 || fmt_reg == ccrf_pkg::FMT_B5G6R5) ?
                         ccrf_pkg::BYTES_16BPP : ccrf_pkg::BYTES_32BPP;
            fill_colour = clear_pixel(fmt_reg);
            col_n = 0;
            row_n = 0;
            x_off = '0;
            sum = 64'(base_reg) + 64'(q.fl) * 64'(slice_stride_reg)
                + 64'(q.y) * 64'(row_stride_reg) + 64'(q.x) * 64'(fill_bytes);
            layer_addr = sum[47:0];
            row_addr = layer_addr;
            fill_busy = wid_n != 0 && hgt_n != 0 && q.fl <= q.ll;
            return;
        end
        if (!fill_busy) return;
        lc = col_n + 1 >= wid_n;
        lr = row_n + 1 >= hgt_n;
        lst = lc && lr && layer_cur >= layer_last;
        wr.addr = row_addr + x_off;
        wr.data = fill_colour;
        wr.nbytes = fill_bytes;
        wr.last = lst;
        pending_writes.push_back(wr);
        if (lst) begin
            fill_busy = 0;
        end else if (!lc) begin
            col_n++;
            x_off = x_off + 48'(fill_bytes);
        end else begin
            col_n = 0;
            x_off = '0;
            if (!lr) begin
                row_n++;
                row_addr = row_addr + 48'(row_stride_reg);
            end else begin
                row_n = 0;
                layer_cur = layer_cur + 1;
                layer_addr = layer_addr + 48'(slice_stride_reg);
                row_addr = layer_addr;
            end
        end
    endtask

    task automatic send_req(input fill_req_t q);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= q.tick;
        s_axis_tdata <= {q.ll, q.fl, q.h, q.w, q.y, q.x};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_fill(q);
        items_sent++;
        if (!q.tick) starts_sent++;
    endtask

    task automatic send_ticks(input int n);
        fill_req_t q;
        q = '{tick: 1, default: '0};
        q.x = 14'($urandom);
        q.y = 14'($urandom);
        q.w = 15'($urandom);
        q.h = 15'($urandom);
        q.fl = 11'($urandom);
        q.ll = 11'($urandom);
        repeat (n) send_req(q);
    endtask

    // start a fill and tick it through to the end, plus some surplus ticks
    task automatic run_fill(input bit [13:0] x, input bit [13:0] y, input bit [14:0] w,
                            input bit [14:0] h, input bit [10:0] fl, input bit [10:0] ll,
                            input int surplus);
        fill_req_t q;
        int n;
        q = '{tick: 0, x: x, y: y, w: w, h: h, fl: fl, ll: ll};
        send_req(q);
        n = (w != 0 && h != 0 && fl <= ll) ? int'(w) * int'(h) * (int'(ll) - int'(fl) + 1) : 0;
        send_ticks(n + surplus);
    endtask

    // let the block drain before touching registers
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(input ccrf_pkg::cfg_reg_t r, input logic [47:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= r;
        cfg_wr_data <= v;
        @(posedge aclk);
        case (r)
            ccrf_pkg::REG_PIXEL_FORMAT: fmt_reg = ccrf_pkg::pix_fmt_t'(v[2:0]);
            ccrf_pkg::REG_CLEAR_RED:    clear_reg[0] = v[31:0];
            ccrf_pkg::REG_CLEAR_GREEN:  clear_reg[1] = v[31:0];
            ccrf_pkg::REG_CLEAR_BLUE:   clear_reg[2] = v[31:0];
            ccrf_pkg::REG_CLEAR_ALPHA:  clear_reg[3] = v[31:0];
            ccrf_pkg::REG_SURFACE_BASE: base_reg = v;
            ccrf_pkg::REG_ROW_STRIDE:   row_stride_reg = v[31:0];
            ccrf_pkg::REG_SLICE_STRIDE: slice_stride_reg = v[31:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input ccrf_pkg::pix_fmt_t f, input logic [31:0] r,
                                input logic [31:0] g, input logic [31:0] b,
                                input logic [31:0] a, input logic [47:0] base,
                                input logic [31:0] rs, input logic [31:0] ls);
        write_reg(ccrf_pkg::REG_PIXEL_FORMAT, 48'(f));
        write_reg(ccrf_pkg::REG_CLEAR_RED, 48'(r));
        write_reg(ccrf_pkg::REG_CLEAR_GREEN, 48'(g));
        write_reg(ccrf_pkg::REG_CLEAR_BLUE, 48'(b));
        write_reg(ccrf_pkg::REG_CLEAR_ALPHA, 48'(a));
        write_reg(ccrf_pkg::REG_SURFACE_BASE, base);
        write_reg(ccrf_pkg::REG_ROW_STRIDE, 48'(rs));
        write_reg(ccrf_pkg::REG_SLICE_STRIDE, 48'(ls));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_colour();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'h3F800000;
            2: return 32'h80000000;
            3: return 32'h7FC00000;
            4: return 32'h7F800000;
            5: return $urandom_range(32'h3F800001, 32'h7F7FFFFF);
            6: return $urandom;
            default: return $urandom_range(1, 32'h3F7FFFFF);
        endcase
    endfunction

    function automatic logic [31:0] pick_stride();
        case ($urandom_range(0, 6))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return $urandom;
            default: return $urandom_range(1, 64) * 4;
        endcase
    endfunction

    task automatic rand_config();
        logic [47:0] base;
        case ($urandom_range(0, 3))
            0: base = '0;
            1: base = '1;
            default: base = 48'({$urandom, $urandom});
        endcase
        program_regs(ccrf_pkg::pix_fmt_t'($urandom_range(0, 7)), pick_colour(), pick_colour(),
                     pick_colour(), pick_colour(), base, pick_stride(), pick_stride());
    endtask

    // ---------------- tests ----------------

    task automatic test_idle_ticks();
        send_ticks(3);
        run_fill(14'd0, 14'd0, 15'd2, 15'd2, 11'd0, 11'd1, 2);
        quiesce();
    endtask

    task automatic test_formats();
        logic [31:0] ramp [5] = '{32'h0, 32'h3F000000, 32'h3E800000, 32'h3F7FFFFF,
                                  32'h00000001};
        for (int f = 0; f < 8; f++) begin
            program_regs(ccrf_pkg::pix_fmt_t'(f), ramp[f % 5], ramp[(f + 1) % 5],
                         32'h3F800000, ramp[(f + 3) % 5], 48'(f * 4096), 32'd256, 32'd65536);
            run_fill(14'(f), 14'(f), 15'd3, 15'd1, 11'd0, 11'd0, 0);
            quiesce();
        end
        // negative, nan, infinity channels
        program_regs(ccrf_pkg::FMT_RGB10A2, 32'h80000000, 32'h7FC00000, 32'h7F800000,
                     32'hBF800000, '0, 32'd16, 32'd64);
        run_fill(14'd1, 14'd1, 15'd2, 15'd2, 11'd0, 11'd0, 0);
        quiesce();
    endtask

    task automatic test_edge_rects();
        fill_req_t q;
        program_regs(ccrf_pkg::FMT_BGRX8, 32'h3F000000, 32'h3F000000, 32'h3F000000, 32'h0,
                     '1, 32'hFFFFFFFF, 32'hFFFFFFFF);
        // far corner, top layer, addresses wrap
        run_fill(14'h3FFF, 14'h3FFF, 15'd2, 15'd2, 11'h7FF, 11'h7FF, 1);
        run_fill(14'd5, 14'd5, 15'd0, 15'd3, 11'd0, 11'd0, 2);     // zero width
        run_fill(14'd5, 14'd5, 15'd3, 15'd0, 11'd0, 11'd0, 2);     // zero height
        run_fill(14'd5, 14'd5, 15'd2, 15'd2, 11'd9, 11'd3, 2);     // layers reversed
        // oversize width, aborted by a fresh start
        q = '{tick: 0, x: 0, y: 0, w: 15'h7FFF, h: 15'h7FFF, fl: 0, ll: 11'h7FF};
        send_req(q);
        send_ticks(4);
        run_fill(14'd2, 14'd3, 15'd1, 15'd1, 11'd0, 11'd2, 0);
        quiesce();
        program_regs(ccrf_pkg::FMT_B5G6R5, 32'h3F7FFFFF, 32'h3E000000, 32'h3C000000,
                     32'h3F800000, 48'h1000, 32'h0, 32'h0);  // zero strides repeat addresses
        run_fill(14'd0, 14'd0, 15'd2, 15'd2, 11'd0, 11'd1, 0);
        quiesce();
    endtask

    task automatic test_backpressure();
        rand_config();
        long_hold = 1;
        run_fill(14'd7, 14'd9, 15'd8, 15'd4, 11'd1, 11'd2, 0);
        quiesce();
    endtask

    task automatic test_random_fills(input int budget);
        fill_req_t q;
        int target;
        target = items_sent + budget;
        rand_config();
        while (items_sent < target) begin
            if ($urandom_range(0, 5) == 0) begin
                q.tick = 0;
                q.x = 14'($urandom);
                q.y = 14'($urandom);
                q.w = 15'($urandom);
                q.h = 15'($urandom);
                q.fl = 11'($urandom);
                q.ll = 11'($urandom);
                send_req(q);
                send_ticks($urandom_range(0, 6));
            end else begin
                q.fl = 11'($urandom);
                run_fill(14'($urandom), 14'($urandom), 15'($urandom_range(1, 5)),
                         15'($urandom_range(1, 3)), q.fl, q.fl + 11'($urandom_range(0, 2)),
                         $urandom_range(0, 3) == 0 ? 1 : 0);
            end
        end
        quiesce();
    endtask

    // ---------------- receiver, checker, watchdog ----------------

    initial begin
        forever begin
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (200) @(posedge aclk);
                long_hold = 0;
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        pixel_wr_t exp_wr;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_writes.size() == 0) begin
                $error("pixel write with none expected: addr %h", m_axis_tdata[47:0]);
                errors++;
            end else begin
                exp_wr = pending_writes.pop_front();
                writes_checked++;
                if (m_axis_tdata[47:0] !== exp_wr.addr) begin
                    $error("write_address exp %h got %h", exp_wr.addr, m_axis_tdata[47:0]);
                    errors++;
                end
                if (m_axis_tdata[79:48] !== exp_wr.data) begin
                    $error("write_data exp %h got %h", exp_wr.data, m_axis_tdata[79:48]);
                    errors++;
                end
                if (m_axis_tdata[82:80] !== exp_wr.nbytes) begin
                    $error("write_bytes exp %0d got %0d", exp_wr.nbytes, m_axis_tdata[82:80]);
                    errors++;
                end
                if (m_axis_tlast !== exp_wr.last) begin
                    $error("last_write exp %0b got %0b", exp_wr.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_ticks();
        test_formats();
        test_edge_rects();
        test_backpressure();
        for (int p = 0; p < 7; p++) test_random_fills(150);
        idle_on = 0;
        test_random_fills(150);
        if (pending_writes.size() != 0) errors++;
        $display("covered %0d transfers in (%0d starts) and %0d checked pixel writes,",
                 items_sent, starts_sent, writes_checked);
        $display("all pixel formats, edge rectangles, aborts and long output stalls");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### clear_color_rect_fill.f
hw/rtl/ccrf_pkg.sv
hw/rtl/ccrf_fifo.sv
hw/rtl/ccrf_front.sv
hw/rtl/ccrf_unorm.sv
hw/rtl/ccrf_setup.sv
hw/rtl/ccrf_back.sv
hw/rtl/clear_color_rect_fill.sv
hw/rtl/ccrf_checker.sv
tb/tb_clear_color_rect_fill.sv
